>>> hw/rtl/i2cm_pkg.sv
package i2cm_pkg;

    localparam int unsigned DELAY_W   = 16;
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned BIT_CNT_W = 4;
    localparam int unsigned PHASE_W   = 3;
    localparam int unsigned ADDR_W    = 3;
    localparam int unsigned DATA_W    = 32;
    localparam int unsigned QDEPTH    = 2;
    localparam int unsigned QPTR_W    = $clog2(QDEPTH);
    localparam int unsigned QCNT_W    = $clog2(QDEPTH + 1);

    localparam logic [DELAY_W-1:0]   DELAY_RESET = 16'd100;
    localparam logic [0:0]           REG_DELAY   = 1'b0;
    localparam logic [BIT_CNT_W-1:0] LAST_BIT    = 4'd7;
    localparam logic [BIT_CNT_W-1:0] BITS_BYTE   = 4'd8;

    localparam logic [2:0] KIND_NONE  = 3'd0;
    localparam logic [2:0] KIND_START = 3'd1;
    localparam logic [2:0] KIND_STOP  = 3'd2;
    localparam logic [2:0] KIND_WRITE = 3'd3;
    localparam logic [2:0] KIND_READ  = 3'd4;

    localparam logic [PHASE_W-1:0] PH_0 = 3'd0;
    localparam logic [PHASE_W-1:0] PH_1 = 3'd1;
    localparam logic [PHASE_W-1:0] PH_2 = 3'd2;
    localparam logic [PHASE_W-1:0] PH_3 = 3'd3;
    localparam logic [PHASE_W-1:0] PH_4 = 3'd4;
    localparam logic [PHASE_W-1:0] PH_5 = 3'd5;

    typedef enum logic [2:0] {
        OP_IDLE,
        OP_START,
        OP_STOP,
        OP_WRITE,
        OP_READ
    } op_t;

    typedef struct packed {
        logic [2:0]        kind;
        logic [BYTE_W-1:0] tx_byte;
        logic              send_nack;
        logic              sda_in;
    } i2cm_in_t;

    typedef struct packed {
        logic              scl_out;
        logic              sda_out;
        logic              busy_res;
        logic              done_res;
        logic [BYTE_W-1:0] rx_byte;
        logic              ack_seen;
    } i2cm_out_t;

    typedef struct packed {
        op_t               cmd;
        logic [BYTE_W-1:0] tx_byte;
        logic              send_nack;
        logic              sda_in;
    } i2cm_item_t;

    typedef struct packed {
        logic              full;
        logic              empty;
        logic [QCNT_W-1:0] count;
    } i2cm_qstat_t;

endpackage

>>> hw/rtl/i2cm_front.sv
module i2cm_front
    import i2cm_pkg::*;
(
    input  logic        cmd_valid,
    output logic        cmd_stall,
    input  i2cm_in_t    cmd_item,
    input  i2cm_qstat_t qstat,
    output logic        push,
    output i2cm_item_t  push_item
);

    always_comb
    begin
        push_item.tx_byte   = cmd_item.tx_byte;
        push_item.send_nack = cmd_item.send_nack;
        push_item.sda_in    = cmd_item.sda_in;
        unique case (cmd_item.kind)
            KIND_START: push_item.cmd = OP_START;
            KIND_STOP:  push_item.cmd = OP_STOP;
            KIND_WRITE: push_item.cmd = OP_WRITE;
            KIND_READ:  push_item.cmd = OP_READ;
            default:    push_item.cmd = OP_IDLE;
        endcase
    end

    assign cmd_stall = qstat.full;
    assign push      = cmd_valid && !qstat.full;

endmodule

>>> hw/rtl/i2cm_queue.sv
module i2cm_queue
    import i2cm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  i2cm_item_t  push_item,
    input  logic        pop,
    output i2cm_item_t  head_item,
    output i2cm_qstat_t qstat
);

    i2cm_item_t        mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign head_item   = mem_reg[rd_ptr_reg];
    assign qstat.full  = (count_reg == QCNT_W'(QDEPTH));
    assign qstat.empty = (count_reg == '0);
    assign qstat.count = count_reg;

endmodule

>>> hw/rtl/i2cm_engine.sv
module i2cm_engine
    import i2cm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [DELAY_W-1:0] delay_ticks,
    input  i2cm_item_t         head_item,
    input  i2cm_qstat_t        qstat,
    output logic               pop,
    output logic               res_valid,
    input  logic               res_stall,
    output i2cm_out_t          res_item
);

    op_t                  op_reg;
    op_t                  op_next;
    logic [PHASE_W-1:0]   phase_reg;
    logic [PHASE_W-1:0]   phase_next;
    logic [BIT_CNT_W-1:0] bit_reg;
    logic [BIT_CNT_W-1:0] bit_next;
    logic [DELAY_W-1:0]   tick_reg;
    logic [DELAY_W-1:0]   tick_next;
    logic [BYTE_W-1:0]    shift_reg;
    logic [BYTE_W-1:0]    shift_next;
    logic                 nack_reg;
    logic                 nack_next;
    logic                 scl_reg;
    logic                 scl_next;
    logic                 sda_reg;
    logic                 sda_next;
    logic                 ack_reg;
    logic                 ack_next;
    logic [BYTE_W-1:0]    rx_reg;
    logic [BYTE_W-1:0]    rx_next;
    logic                 res_valid_reg;
    i2cm_out_t            res_item_reg;

    logic [DELAY_W-1:0]   slot_len;
    logic                 slot_end;
    logic                 fin;
    logic                 cmd_go;

    assign pop      = !qstat.empty && (!res_valid_reg || !res_stall);
    assign slot_len = (delay_ticks == '0) ? DELAY_W'(1) : delay_ticks;
    assign slot_end = ({1'b0, tick_reg} + 17'd1) >= {1'b0, slot_len};
    assign cmd_go   = pop && (op_reg == OP_IDLE) && (head_item.cmd != OP_IDLE);

    // sequencing: command, phase, bit and tick counters
    always_comb
    begin
        op_next    = op_reg;
        phase_next = phase_reg;
        bit_next   = bit_reg;
        tick_next  = tick_reg;
        fin        = 1'b0;
        if (cmd_go)
        begin
            op_next    = head_item.cmd;
            phase_next = PH_0;
            bit_next   = '0;
            tick_next  = '0;
        end
        else if (pop && (op_reg != OP_IDLE))
        begin
            tick_next = tick_reg + 1'b1;
            if (slot_end)
            begin
                tick_next = '0;
                unique case (op_reg)
                    OP_START, OP_STOP:
                    begin
                        if (phase_reg == PH_0)
                            phase_next = PH_1;
                        else if (phase_reg == PH_1)
                            phase_next = PH_2;
                        else
                            fin = 1'b1;
                    end
                    OP_WRITE:
                    begin
                        if (bit_reg < BITS_BYTE)
                        begin
                            if (phase_reg == PH_0)
                                phase_next = PH_1;
                            else
                            begin
                                phase_next = PH_0;
                                bit_next   = bit_reg + 1'b1;
                            end
                        end
                        else if (phase_reg == PH_0)
                            phase_next = PH_1;
                        else if (phase_reg == PH_1)
                            phase_next = PH_2;
                        else
                            fin = 1'b1;
                    end
                    OP_READ:
                    begin
                        unique case (phase_reg)
                            PH_0: phase_next = PH_1;
                            PH_1: phase_next = PH_2;
                            PH_2: phase_next = PH_3;
                            PH_3:
                            begin
                                bit_next   = bit_reg + 1'b1;
                                phase_next = (bit_reg < LAST_BIT) ? PH_1 : PH_4;
                            end
                            PH_4: phase_next = PH_5;
                            default: fin = 1'b1;
                        endcase
                    end
                    default: fin = 1'b1;
                endcase
            end
            if (fin)
            begin
                op_next    = OP_IDLE;
                phase_next = PH_0;
                bit_next   = '0;
                tick_next  = '0;
            end
        end
    end

    // line levels and data registers
    always_comb
    begin
        scl_next   = scl_reg;
        sda_next   = sda_reg;
        shift_next = shift_reg;
        nack_next  = nack_reg;
        ack_next   = ack_reg;
        rx_next    = rx_reg;
        if (cmd_go)
        begin
            unique case (head_item.cmd)
                OP_START:
                begin
                    scl_next = 1'b1;
                    sda_next = 1'b1;
                end
                OP_STOP:  sda_next = 1'b0;
                OP_WRITE:
                begin
                    shift_next = head_item.tx_byte;
                    sda_next   = head_item.tx_byte[BYTE_W-1];
                end
                default:
                begin
                    nack_next  = head_item.send_nack;
                    shift_next = '0;
                    sda_next   = 1'b1;
                end
            endcase
        end
        else if (pop && (op_reg != OP_IDLE) && slot_end)
        begin
            unique case (op_reg)
                OP_START:
                begin
                    if (phase_reg == PH_0)
                        sda_next = 1'b0;
                    else if (phase_reg == PH_1)
                        scl_next = 1'b0;
                end
                OP_STOP:
                begin
                    if (phase_reg == PH_0)
                        scl_next = 1'b1;
                    else if (phase_reg == PH_1)
                        sda_next = 1'b1;
                end
                OP_WRITE:
                begin
                    if (bit_reg < BITS_BYTE)
                    begin
                        if (phase_reg == PH_0)
                            scl_next = 1'b1;
                        else
                        begin
                            scl_next   = 1'b0;
                            shift_next = {shift_reg[BYTE_W-2:0], 1'b0};
                            sda_next   = (bit_reg < LAST_BIT) ? shift_reg[BYTE_W-2] : 1'b1;
                        end
                    end
                    else if (phase_reg == PH_0)
                        scl_next = 1'b1;
                    else if (phase_reg == PH_1)
                    begin
                        ack_next = head_item.sda_in;
                        scl_next = 1'b0;
                    end
                end
                OP_READ:
                begin
                    unique case (phase_reg)
                        PH_0: scl_next = 1'b1;
                        PH_1: ;
                        PH_2:
                        begin
                            shift_next = {shift_reg[BYTE_W-2:0], head_item.sda_in};
                            scl_next   = 1'b0;
                        end
                        PH_3:
                        begin
                            if (bit_reg < LAST_BIT)
                                scl_next = 1'b1;
                            else
                                sda_next = nack_reg;
                        end
                        PH_4: scl_next = 1'b1;
                        default:
                        begin
                            scl_next = 1'b0;
                            sda_next = 1'b1;
                            rx_next  = shift_reg;
                        end
                    endcase
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg        <= OP_IDLE;
            phase_reg     <= PH_0;
            bit_reg       <= '0;
            tick_reg      <= '0;
            shift_reg     <= '0;
            nack_reg      <= 1'b0;
            scl_reg       <= 1'b1;
            sda_reg       <= 1'b1;
            ack_reg       <= 1'b0;
            rx_reg        <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            op_reg    <= op_next;
            phase_reg <= phase_next;
            bit_reg   <= bit_next;
            tick_reg  <= tick_next;
            shift_reg <= shift_next;
            nack_reg  <= nack_next;
            scl_reg   <= scl_next;
            sda_reg   <= sda_next;
            ack_reg   <= ack_next;
            rx_reg    <= rx_next;
            if (pop)
                res_valid_reg <= 1'b1;
            else if (!res_stall)
                res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            res_item_reg.scl_out  <= scl_next;
            res_item_reg.sda_out  <= sda_next;
            res_item_reg.busy_res <= (op_next != OP_IDLE);
            res_item_reg.done_res <= fin;
            res_item_reg.rx_byte  <= rx_next;
            res_item_reg.ack_seen <= ack_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_item  = res_item_reg;

endmodule

>>> hw/rtl/i2c_master_byte_engine_core.sv
// i2c master byte engine
// each command transaction is one tick of the bit engine: kind (none, start,
// stop, write byte, read byte), tx_byte, send_nack and the sampled sda level.
// a command is taken only while no command runs; other ticks just advance
// the current delay slot. each transaction yields exactly one result
// transaction with the scl/sda drive after that tick, busy, a done pulse,
// the last received byte and the last write acknowledge.
// throughput is one transaction per cycle while the result is not stalled; a
// command is written into the queue at the accept edge, and the engine step
// is then registered into the result register. the engine state update of one
// tick sets the rate.
// delay_ticks (apb offset 0x0, reset 100, 0 acts as 1) sets ticks per slot.
// reset releases both lines, clears the queue and the result valid flag.
// a stalled result holds; the 2-entry queue keeps taking commands until
// full, then cmd_stall rises.
module i2c_master_byte_engine_core
    import i2cm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_stall,
    input  i2cm_in_t          cmd_item,
    output logic              res_valid,
    input  logic              res_stall,
    output i2cm_out_t         res_item,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    logic [DELAY_W-1:0] delay_reg;
    logic               cfg_wr;
    logic               push;
    logic               pop;
    i2cm_item_t         push_item;
    i2cm_item_t         head_item;
    i2cm_qstat_t        qstat;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[ADDR_W-1] == REG_DELAY);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            delay_reg <= DELAY_RESET;
        else if (cfg_wr)
            delay_reg <= pwdata[DELAY_W-1:0];
    end

    assign prdata = (paddr[ADDR_W-1] == REG_DELAY) ?
                    {{(DATA_W-DELAY_W){1'b0}}, delay_reg} : '0;

    i2cm_front u_front (
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_item  (cmd_item),
        .qstat     (qstat),
        .push      (push),
        .push_item (push_item)
    );

    i2cm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head_item (head_item),
        .qstat     (qstat)
    );

    i2cm_engine u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .delay_ticks (delay_reg),
        .head_item   (head_item),
        .qstat       (qstat),
        .pop         (pop),
        .res_valid   (res_valid),
        .res_stall   (res_stall),
        .res_item    (res_item)
    );

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        qstat.count <= QCNT_W'(QDEPTH))
        else $error("queue count out of range");

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_item.done_res |-> !res_item.busy_res)
        else $error("done reported while still busy");

    a_pop_fills_result: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> res_valid)
        else $error("queue pop without a result");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        qstat.empty |-> !pop)
        else $error("pop from empty queue");

endmodule
